[design/byte_stream_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer RTL.
`ifndef BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define BST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define BST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define BST_ASSERT(lbl, prop, msg)
`define BST_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/bst_pkg.sv]
// Types, constants and the byte classifier of the byte stream tokenizer.
`default_nettype none

package bst_pkg;

  // Width of the running byte position; offsets leave the block in 16 bits.
  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned TOK_W       = 16;
  localparam int unsigned KIND_W      = 5;
  localparam logic [TOK_W-1:0] LEN_MAX = {TOK_W{1'b1}};

  // Token kinds; punctuation kinds 0 to 15 follow the table below.
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd16;
  localparam logic [KIND_W-1:0] KIND_STRING  = 5'd17;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_NEWLINE = 5'd19;
  localparam logic [KIND_W-1:0] KIND_END     = 5'd20;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd21;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_UNDER  = 8'h5f;

  localparam logic [7:0] PUNCT_CHARS [16] = '{
    8'h2c, 8'h2e, 8'h3b, 8'h3d, 8'h2a, 8'h26, 8'h2b, 8'h2d,
    8'h3e, 8'h3c, 8'h28, 8'h29, 8'h7b, 8'h7d, 8'h5b, 8'h5d
  };

  // Queue between classifier and scanner.
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Token buffer at the output of the scanner.
  localparam int unsigned OB_DEPTH = 4;
  localparam int unsigned OB_PTR_W = $clog2(OB_DEPTH);
  localparam int unsigned OB_CNT_W = $clog2(OB_DEPTH + 1);

  typedef enum logic [3:0] {
    C_ZERO, C_BLANK, C_PUNCT, C_NEWLINE, C_QUOTE,
    C_LETTER, C_DIGIT, C_UNDER, C_BSLASH, C_OTHER
  } cls_e;

  typedef struct packed {
    cls_e             cls;
    logic [3:0]       punct;
    logic [TOK_W-1:0] pos;
    logic [TOK_W-1:0] pos_plus;
  } q_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  start;
    logic [TOK_W-1:0]  len;
    logic              last;
  } tok_t;

  function automatic logic [TOK_W-1:0] to_tok16(input logic [OFFSET_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[TOK_W-1:0];
  endfunction

  function automatic cls_e classify(input logic [7:0] c);
    cls_e r;
    r = C_OTHER;
    if (c == CH_NUL) r = C_ZERO;
    else if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b || c == 8'h0c) r = C_BLANK;
    else if (c == CH_NL) r = C_NEWLINE;
    else if (c == CH_QUOTE) r = C_QUOTE;
    else if (c == CH_BSLASH) r = C_BSLASH;
    else if (c == CH_UNDER) r = C_UNDER;
    else if ((c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)) r = C_LETTER;
    else if (c >= 8'h30 && c <= 8'h39) r = C_DIGIT;
    for (int i = 0; i < 16; i++) begin
      if (c == PUNCT_CHARS[i]) r = C_PUNCT;
    end
    return r;
  endfunction

  function automatic logic [3:0] punct_index(input logic [7:0] c);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (c == PUNCT_CHARS[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/bst_front.sv]
// Input side: accepts bytes, classifies them and tracks the byte position.
`default_nettype none

module bst_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         char_in_i,
  input  wire logic               q_full_i,
  output logic                    q_push_o,
  output bst_pkg::q_entry_t       q_data_o
);
  import bst_pkg::*;

  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_plus;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign pos_plus   = pos_q + OFFSET_BITS'(1);

  always_comb begin
    q_data_o.cls      = classify(char_in_i);
    q_data_o.punct    = punct_index(char_in_i);
    q_data_o.pos      = to_tok16(pos_q);
    q_data_o.pos_plus = to_tok16(pos_plus);
  end

  // A zero byte ends the stream and restarts the offsets.
  always_comb begin
    pos_d = pos_q;
    if (q_push_o) begin
      pos_d = (char_in_i == CH_NUL) ? '0 : pos_plus;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

[design/bst_queue.sv]
// Short queue of classified bytes between the front and the scanner.
`default_nettype none
`include "byte_stream_tokenizer_defines.svh"

module bst_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bst_pkg::q_entry_t  push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output bst_pkg::q_entry_t       head_o
);
  import bst_pkg::*;

  q_entry_t           mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + Q_PTR_W'(1) : wr_q;
    rd_d  = do_pop ? rd_q + Q_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `BST_ASSERT(q_cnt_bound, cnt_q <= Q_CNT_W'(Q_DEPTH), "queue count above depth")
  `BST_ASSERT(q_ptr_track, (cnt_q == '0 || full_o) |-> (wr_q == rd_q), "queue pointers off")
  `BST_ASSERT(q_head_hold, (valid_o && !pop_i) |=> $stable(head_o), "queue head moved")

endmodule

`default_nettype wire

[design/bst_back.sv]
// Scanner: runs the token state machine and buffers the tokens it emits.
`default_nettype none
`include "byte_stream_tokenizer_defines.svh"

module bst_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  input  wire bst_pkg::q_entry_t          q_head_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output bst_pkg::tok_t                   out_tok_o
);
  import bst_pkg::*;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_IDENT  = 5'b00010,
    MODE_NUMBER = 5'b00100,
    MODE_STRING = 5'b01000,
    MODE_ESCAPE = 5'b10000
  } mode_e;

  mode_e             mode_q, mode_d;
  logic [TOK_W-1:0]  start_q, start_d, len_q, len_d, len_grow;

  tok_t                ob_q [OB_DEPTH];
  logic [OB_PTR_W-1:0] ob_wr_q, ob_wr_d, ob_rd_q, ob_rd_d;
  logic [OB_CNT_W-1:0] ob_cnt_q, ob_cnt_d;

  q_entry_t          e;
  logic              take, out_pop, is_zero;
  logic              idle_emit, idle_open, use_idle, close_v;
  logic [KIND_W-1:0] idle_kind, close_kind;
  mode_e             idle_mode;
  logic [TOK_W-1:0]  idle_start, idle_len;
  tok_t              t0, t1;
  logic [1:0]        n;

  assign e        = q_head_i;
  assign is_zero  = (e.cls == C_ZERO);
  // Room for two tokens is required before a byte is taken.
  assign take     = q_valid_i && (ob_cnt_q <= OB_CNT_W'(OB_DEPTH - 2));
  assign q_pop_o  = take;
  assign len_grow = (len_q == LEN_MAX) ? LEN_MAX : len_q + TOK_W'(1);

  // What the byte does when no token is open.
  always_comb begin
    idle_emit  = 1'b0;
    idle_open  = 1'b0;
    idle_kind  = KIND_UNKNOWN;
    idle_mode  = MODE_IDLE;
    idle_start = e.pos;
    idle_len   = TOK_W'(1);
    unique case (e.cls) inside
      C_ZERO: begin
        idle_emit = 1'b1;
        idle_kind = KIND_END;
      end
      C_BLANK: ;
      C_PUNCT: begin
        idle_emit = 1'b1;
        idle_kind = {1'b0, e.punct};
      end
      C_NEWLINE: begin
        idle_emit = 1'b1;
        idle_kind = KIND_NEWLINE;
      end
      C_QUOTE: begin
        idle_open  = 1'b1;
        idle_mode  = MODE_STRING;
        idle_start = e.pos_plus;
        idle_len   = '0;
      end
      C_LETTER: begin
        idle_open = 1'b1;
        idle_mode = MODE_IDENT;
      end
      C_DIGIT: begin
        idle_open = 1'b1;
        idle_mode = MODE_NUMBER;
      end
      C_UNDER, C_BSLASH, C_OTHER: begin
        idle_emit = 1'b1;
      end
      default: begin
        idle_emit = 1'b1;
      end
    endcase
  end

  always_comb begin
    mode_d     = mode_q;
    start_d    = start_q;
    len_d      = len_q;
    use_idle   = 1'b0;
    close_v    = 1'b0;
    close_kind = KIND_IDENT;
    unique case (mode_q)
      MODE_IDLE: use_idle = 1'b1;
      MODE_IDENT: begin
        if (e.cls == C_LETTER || e.cls == C_DIGIT || e.cls == C_UNDER) begin
          len_d = len_grow;
        end else begin
          close_v  = 1'b1;
          use_idle = 1'b1;
        end
      end
      MODE_NUMBER: begin
        close_kind = KIND_NUMBER;
        if (e.cls == C_DIGIT) begin
          len_d = len_grow;
        end else begin
          close_v  = 1'b1;
          use_idle = 1'b1;
        end
      end
      MODE_STRING: begin
        close_kind = KIND_STRING;
        if (is_zero) begin
          close_v  = 1'b1;
          use_idle = 1'b1;
        end else if (e.cls == C_QUOTE) begin
          close_v = 1'b1;
        end else begin
          len_d = len_grow;
          if (e.cls == C_BSLASH) mode_d = MODE_ESCAPE;
        end
      end
      MODE_ESCAPE: begin
        close_kind = KIND_STRING;
        if (is_zero) begin
          close_v  = 1'b1;
          use_idle = 1'b1;
        end else begin
          len_d  = len_grow;
          mode_d = MODE_STRING;
        end
      end
      default: use_idle = 1'b1;
    endcase

    if (close_v) mode_d = MODE_IDLE;
    if (use_idle && idle_open) begin
      mode_d  = idle_mode;
      start_d = idle_start;
      len_d   = idle_len;
    end
    if (is_zero) begin
      mode_d  = MODE_IDLE;
      start_d = '0;
      len_d   = '0;
    end
  end

  // Up to two tokens per byte: the closed open token, then the byte's own.
  always_comb begin
    t0 = '{kind: close_kind, start: start_q, len: len_q, last: 1'b0};
    t1 = '{kind: idle_kind, start: e.pos, len: TOK_W'(1), last: 1'b0};
    n  = 2'd0;
    if (close_v) begin
      if (use_idle && idle_emit) begin
        n       = 2'd2;
        t1.last = 1'b1;
      end else begin
        n       = 2'd1;
        t0.last = 1'b1;
      end
    end else if (use_idle && idle_emit) begin
      n  = 2'd1;
      t0 = '{kind: idle_kind, start: e.pos, len: TOK_W'(1), last: 1'b1};
    end
  end

  assign out_valid_o = (ob_cnt_q != '0);
  assign out_tok_o   = ob_q[ob_rd_q];
  assign out_pop     = out_valid_o && out_ready_i;

  always_comb begin
    ob_wr_d  = take ? ob_wr_q + OB_PTR_W'(n) : ob_wr_q;
    ob_rd_d  = out_pop ? ob_rd_q + OB_PTR_W'(1) : ob_rd_q;
    ob_cnt_d = ob_cnt_q + (take ? OB_CNT_W'(n) : '0) - OB_CNT_W'(out_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      start_q  <= '0;
      len_q    <= '0;
      ob_wr_q  <= '0;
      ob_rd_q  <= '0;
      ob_cnt_q <= '0;
    end else begin
      if (take) begin
        mode_q  <= mode_d;
        start_q <= start_d;
        len_q   <= len_d;
      end
      ob_wr_q  <= ob_wr_d;
      ob_rd_q  <= ob_rd_d;
      ob_cnt_q <= ob_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && n != 2'd0) begin
      ob_q[ob_wr_q] <= t0;
    end
    if (take && n == 2'd2) begin
      ob_q[ob_wr_q + OB_PTR_W'(1)] <= t1;
    end
  end

  `BST_ASSERT(ob_cnt_bound, ob_cnt_q <= OB_CNT_W'(OB_DEPTH), "token buffer overflow")
  `BST_ASSERT(zero_emits_end, (take && is_zero) |-> (n != 2'd0), "zero byte produced no token")
  `BST_ASSERT(zero_clears_scan,
              (take && is_zero) |=> (mode_q == MODE_IDLE && len_q == '0),
              "zero byte left a token open")

endmodule

`default_nettype wire

[design/byte_stream_tokenizer.sv]
// Top level of the byte stream tokenizer.
//
// Usage: text bytes enter one beat at a time on the char_in channel
// (in_valid_i / in_ready_o). Tokens leave on the token channel
// (out_valid_o / out_ready_i), one token per beat, each with its kind,
// start offset, length and a flag marking the last token caused by a byte.
// A zero byte ends the stream: an open token is closed, an End token
// follows, and offsets restart at zero for the next stream.
//
// Throughput is one byte per cycle while the receiver keeps up. A byte
// that closes an open token and gives a token of its own yields two
// tokens, one beat each; the four-entry byte queue and four-entry token
// buffer absorb the extra beat, and since every such byte needs an open
// token first, tokens never outpace bytes. A byte's first token passes
// through the byte queue and then the token buffer before the output.
//
// Reset empties both queues, returns the scanner to idle and sets the byte
// offset to zero. When the receiver stalls, the token buffer fills, the
// scanner stops taking bytes, the byte queue fills and in_ready_o drops;
// nothing is lost and bytes resume at full rate once tokens drain.
`default_nettype none

module byte_stream_tokenizer (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           char_in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [bst_pkg::KIND_W-1:0] token_kind_o,
  output logic [bst_pkg::TOK_W-1:0]  token_start_o,
  output logic [bst_pkg::TOK_W-1:0]  token_length_o,
  output logic                      last_of_run_o
);
  import bst_pkg::*;

  q_entry_t push_data, head;
  logic     push, full, q_valid, pop;
  tok_t     tok;

  // Classification and offset tracking of incoming bytes.
  bst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_in_i  (char_in_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_data_o   (push_data)
  );

  // Decouples the front from the scanner so each can stall on its own.
  bst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  // Token state machine and output buffer.
  bst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_tok_o   (tok)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.len;
  assign last_of_run_o  = tok.last;

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the byte stream tokenizer: directed and random streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bst_pkg::*;

  // The run is cut off here.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  // Cycles allowed after the last token, so that a stray extra token is seen.
  localparam int unsigned DRAIN_CYCLES = 16;

  // Scanner state of the predictor.
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_STRING, SCAN_ESCAPE
  } scan_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] char_in = 8'h00;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] token_kind;
  logic [TOK_W-1:0] token_start;
  logic [TOK_W-1:0] token_length;
  logic last_of_run;

  // Predictor state: what the scanner is in the middle of, the offset of
  // the next byte, and the start and length of the open token.
  scan_e scan_state = SCAN_IDLE;
  logic [TOK_W-1:0] next_offset = '0;
  logic [TOK_W-1:0] word_start = '0;
  logic [TOK_W-1:0] word_len = '0;

  // Tokens that accepted bytes have caused and that have not left yet.
  tok_t tokens_due[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned ready_hold = 0;
  // When set, both sides insert random idle bursts.
  bit idling = 1'b0;

  byte_stream_tokenizer uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .char_in_i     (char_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .token_kind_o  (token_kind),
    .token_start_o (token_start),
    .token_length_o(token_length),
    .last_of_run_o (last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hang: the run ends as failed once the limit is reached.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: ready drops in random bursts, separated by random
  // stretches of readiness. With idling off it stays high.
  always @(posedge clk) begin
    if (!idling) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end
  end

  // Every token beat is compared with the oldest expected token. The values
  // read here are those from before the edge, which is what the block saw.
  always @(posedge clk) begin : token_check
    tok_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected token: kind %0d, start %0d, length %0d",
               token_kind, token_start, token_length);
        error_count++;
      end else begin
        want = tokens_due.pop_front();
        if (token_kind !== want.kind) begin
          $error("token_kind: expected %0d, actual %0d", want.kind, token_kind);
          error_count++;
        end
        if (token_start !== want.start) begin
          $error("token_start: expected %0d, actual %0d", want.start, token_start);
          error_count++;
        end
        if (token_length !== want.len) begin
          $error("token_length: expected %0d, actual %0d", want.len, token_length);
          error_count++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run);
          error_count++;
        end
      end
    end
  end

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Token lengths stop at the largest value instead of wrapping.
  function automatic logic [TOK_W-1:0] sat_inc(input logic [TOK_W-1:0] n);
    return (n == LEN_MAX) ? n : n + 1'b1;
  endfunction

  function automatic void push_token(input logic [KIND_W-1:0] kind,
                                     input logic [TOK_W-1:0] start,
                                     input logic [TOK_W-1:0] len);
    tok_t t;
    t.kind = kind;
    t.start = start;
    t.len = len;
    t.last = 1'b0;
    tokens_due.push_back(t);
  endfunction

  // Lexes a byte that arrives with no token open: it is skipped, gives a
  // one-byte token, or opens a string, identifier or number.
  task automatic lex_fresh(input logic [7:0] c, input logic [TOK_W-1:0] pos);
    bit hit;
    hit = 1'b0;
    if (c == CH_NUL) begin
      push_token(KIND_END, pos, 16'd1);
    end else if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b || c == 8'h0c) begin
      // Blanks separate tokens and produce nothing.
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (c == PUNCT_CHARS[i]) begin
          push_token(KIND_W'(i), pos, 16'd1);
          hit = 1'b1;
        end
      end
      if (hit) begin
        // Punctuation already emitted.
      end else if (c == CH_NL) begin
        push_token(KIND_NEWLINE, pos, 16'd1);
      end else if (c == CH_QUOTE) begin
        // The string text starts after the quote; this may wrap to zero.
        scan_state = SCAN_STRING;
        word_start = pos + 1'b1;
        word_len = '0;
      end else if (is_letter(c)) begin
        scan_state = SCAN_IDENT;
        word_start = pos;
        word_len = 16'd1;
      end else if (is_digit(c)) begin
        scan_state = SCAN_NUMBER;
        word_start = pos;
        word_len = 16'd1;
      end else begin
        // Anything else, the underscore and high bytes included, is an
        // error token that consumes the byte.
        push_token(KIND_UNKNOWN, pos, 16'd1);
      end
    end
  endtask

  // Works out the tokens that one accepted byte causes and queues them.
  task automatic predict_byte(input logic [7:0] c);
    logic [TOK_W-1:0] pos;
    int unsigned before_n;
    tok_t tail;
    pos = next_offset;
    before_n = tokens_due.size();
    case (scan_state)
      SCAN_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == CH_UNDER) begin
          word_len = sat_inc(word_len);
        end else begin
          // The closing byte is lexed in the same beat, so up to two tokens.
          push_token(KIND_IDENT, word_start, word_len);
          scan_state = SCAN_IDLE;
          lex_fresh(c, pos);
        end
      end
      SCAN_NUMBER: begin
        if (is_digit(c)) begin
          word_len = sat_inc(word_len);
        end else begin
          push_token(KIND_NUMBER, word_start, word_len);
          scan_state = SCAN_IDLE;
          lex_fresh(c, pos);
        end
      end
      SCAN_STRING, SCAN_ESCAPE: begin
        if (c == CH_NUL) begin
          // An unterminated string closes with what it has, then End.
          push_token(KIND_STRING, word_start, word_len);
          push_token(KIND_END, pos, 16'd1);
        end else if (scan_state == SCAN_ESCAPE) begin
          word_len = sat_inc(word_len);
          scan_state = SCAN_STRING;
        end else if (c == CH_QUOTE) begin
          push_token(KIND_STRING, word_start, word_len);
          scan_state = SCAN_IDLE;
        end else begin
          word_len = sat_inc(word_len);
          if (c == CH_BSLASH) begin
            scan_state = SCAN_ESCAPE;
          end
        end
      end
      default: begin
        lex_fresh(c, pos);
      end
    endcase
    if (c == CH_NUL) begin
      next_offset = '0;
      scan_state = SCAN_IDLE;
      word_start = '0;
      word_len = '0;
    end else begin
      next_offset = pos + 1'b1;
    end
    // The last token caused by this byte carries the flag.
    if (tokens_due.size() > before_n) begin
      tail = tokens_due.pop_back();
      tail.last = 1'b1;
      tokens_due.push_back(tail);
    end
  endtask

  // Sends one byte beat. With idling on, valid sometimes drops for a burst
  // first. Valid is left high on return so that back-to-back beats never
  // lower and raise it within one time step.
  task automatic send_byte(input logic [7:0] c);
    if (idling && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_in <= c;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    predict_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7a))
                                : 8'($urandom_range(8'h41, 8'h5a));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  // All sixteen punctuation kinds, newline, every blank, then End.
  task automatic test_punctuation_and_layout();
    send_text(",.;=*&+-><(){}[]");
    send_byte(CH_NL);
    send_byte(8'h20);
    send_byte(8'h09);
    send_byte(8'h0d);
    send_byte(8'h0b);
    send_byte(8'h0c);
    send_byte(CH_NUL);
  endtask

  // Identifiers and numbers closed by a blank, by punctuation, by a letter
  // and by the zero byte; unknown bytes at both ends of the byte range.
  task automatic test_words_and_numbers();
    send_text("ab_9 0123,7q_");
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(8'h01);
    send_text("z");
    send_byte(CH_NUL);
    // An empty stream: End at offset zero straight away.
    send_byte(CH_NUL);
  endtask

  // Escaped quote, empty string, a newline inside a string, and strings
  // cut off by the zero byte, once right after a backslash.
  task automatic test_strings();
    send_text("\"a\\\"b\"\"\"");
    send_text("\"n\nx\"");
    send_text("\"x\\");
    send_byte(CH_NUL);
    send_text("\"tail");
    send_byte(CH_NUL);
  endtask

  // Random text made mostly of well-formed fragments with random content,
  // mixed with noise bytes and strings that break off.
  task automatic test_random_text(input int unsigned budget);
    int unsigned first_byte;
    int unsigned pick;
    int unsigned n;
    logic [7:0] b;
    string symbols;
    symbols = "#@$!?%^~`:'|/";
    first_byte = bytes_sent;
    while (bytes_sent - first_byte < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_byte(rand_letter());
        n = $urandom_range(0, 7);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: send_byte(rand_digit());
            1: send_byte(CH_UNDER);
            default: send_byte(rand_letter());
          endcase
        end
      end else if (pick < 35) begin
        repeat ($urandom_range(1, 6)) send_byte(rand_digit());
      end else if (pick < 50) begin
        send_byte(CH_QUOTE);
        n = $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) begin
            send_byte(CH_BSLASH);
            send_byte(8'($urandom_range(1, 255)));
          end else begin
            b = 8'($urandom_range(1, 255));
            if (b == CH_QUOTE || b == CH_BSLASH) begin
              b = 8'h71;
            end
            send_byte(b);
          end
        end
        if ($urandom_range(0, 9) == 0) begin
          // Broken string: cut off by the zero byte, sometimes mid-escape.
          if ($urandom_range(0, 1) == 0) begin
            send_byte(CH_BSLASH);
          end
          send_byte(CH_NUL);
        end else begin
          send_byte(CH_QUOTE);
        end
      end else if (pick < 65) begin
        send_byte(PUNCT_CHARS[$urandom_range(0, 15)]);
      end else if (pick < 73) begin
        case ($urandom_range(0, 4))
          0: send_byte(8'h20);
          1: send_byte(8'h09);
          2: send_byte(8'h0d);
          3: send_byte(8'h0b);
          default: send_byte(8'h0c);
        endcase
      end else if (pick < 79) begin
        send_byte(CH_NL);
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0: send_byte(CH_UNDER);
          1: send_byte(8'($urandom_range(128, 255)));
          2: send_byte(symbols[$urandom_range(0, symbols.len() - 1)]);
          default: send_byte(8'($urandom_range(1, 8)));
        endcase
      end else if (pick < 93) begin
        send_byte(8'($urandom_range(1, 255)));
      end else begin
        send_byte(CH_NUL);
      end
    end
  endtask

  initial begin : run
    // Reset is held low at the start and released at a rising edge; the
    // predictor starts from the same idle state at offset zero.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    idling = 1'b1;
    test_punctuation_and_layout();
    test_words_and_numbers();
    test_strings();
    test_random_text(1000);

    // The last part of the run goes at full rate on both sides.
    idling = 1'b0;
    test_random_text(300);
    in_valid <= 1'b0;

    // Wait for every expected token, then a little longer so that any
    // extra token the block might still send is caught.
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
